// File: design/ptrq_pkg.sv
package ptrq_pkg;
	localparam int MaxTasks = 16;
	localparam int SlotBits = 4;
	localparam int CntBits = 5;
	localparam int PriBits = 8;
	localparam int ResBits = 16;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_REMOVE = 3'd1,
		OP_SET = 3'd2,
		OP_FIND_READY = 3'd3,
		OP_DISPATCH = 3'd4,
		OP_FIND_WAIT = 3'd5
	} opcode_t;

	localparam logic [1:0] ST_RUNNING = 2'd0;
	localparam logic [1:0] ST_READY = 2'd2;
	localparam logic [1:0] ST_WAITING = 2'd3;

	// last member sits in the lowest bits, so opcode lands at bit 0
	typedef struct packed {
		logic [ResBits-1:0] resource;
		logic [1:0] task_state;
		logic [PriBits-1:0] priority_req;
		logic [SlotBits-1:0] task_slot;
		logic [2:0] opcode;
	} item_t;

	typedef struct packed {
		logic used_idle;
		logic [SlotBits-1:0] result_slot;
		logic found;
		logic error;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch the input item
		logic clr_pos;   // reset the walk position
		logic pos_end;   // set the walk position to the count
		logic step;      // advance the walk position by one
		logic ins_shift; // move entry pos-1 to pos, then step back
		logic rem_shift; // move entry pos+1 to pos, then step
		logic put;       // write the item slot at pos
		logic cnt_inc;
		logic cnt_dec;
		logic wr_fields; // write priority, state and resource tables
		logic wr_state;  // write state and resource tables
		logic set_q;
		logic clr_q;
		logic mark_run;  // mark the chosen slot running
		logic res_hit;   // result is a hit at pos
		logic res_idle;  // result falls back to idle slot
		logic res_err;
		logic res_none;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] opcode;
		logic queued;     // item slot is queued
		logic at_end;     // pos == count
		logic at_zero;    // pos == 0
		logic at_last;    // pos == count - 1
		logic prev_gt;    // entry at pos-1 has priority > item's
		logic is_ready;
		logic is_wait_match;
		logic is_slot;    // entry at pos is the item slot
	} status_t;
endpackage

// File: design/ptrq_datapath.sv
module ptrq_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ptrq_pkg::item_t             item,
	input  logic [ptrq_pkg::SlotBits-1:0] idle_slot,
	input  ptrq_pkg::cmd_t              cmd,
	output ptrq_pkg::status_t           status,
	output ptrq_pkg::result_t           result
);
	import ptrq_pkg::*;

	item_t item_q;
	logic [SlotBits-1:0] order_q [MaxTasks];
	logic [PriBits-1:0] pri_q [MaxTasks];
	logic [1:0] state_q [MaxTasks];
	logic [ResBits-1:0] wait_q [MaxTasks];
	logic [MaxTasks-1:0] queued_q;
	logic [CntBits-1:0] count_q;
	logic [CntBits-1:0] pos_q;
	result_t result_q;

	logic [SlotBits-1:0] pos_idx, prev_idx, ent, prev_ent, mark_slot;
	assign pos_idx = pos_q[SlotBits-1:0];
	assign prev_idx = pos_idx - SlotBits'(1);
	assign ent = order_q[pos_idx];
	assign prev_ent = order_q[prev_idx];
	assign mark_slot = cmd.res_idle ? idle_slot : ent;

	assign status.opcode = item_q.opcode;
	assign status.queued = queued_q[item_q.task_slot];
	assign status.at_end = (pos_q == count_q);
	assign status.at_zero = (pos_q == '0);
	assign status.at_last = (pos_q + CntBits'(1) == count_q);
	assign status.prev_gt = (pri_q[prev_ent] > item_q.priority_req);
	assign status.is_ready = (state_q[ent] == ST_READY);
	assign status.is_wait_match = (state_q[ent] == ST_WAITING)
		&& (wait_q[ent] == item_q.resource);
	assign status.is_slot = (ent == item_q.task_slot);
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q <= '0;
			count_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.set_q) queued_q[item_q.task_slot] <= 1'b1;
			if (cmd.clr_q) queued_q[item_q.task_slot] <= 1'b0;
			if (cmd.cnt_inc) count_q <= count_q + CntBits'(1);
			if (cmd.cnt_dec) count_q <= count_q - CntBits'(1);
			if (cmd.clr_pos) pos_q <= '0;
			else if (cmd.pos_end) pos_q <= count_q;
			else if (cmd.step || cmd.rem_shift) pos_q <= pos_q + CntBits'(1);
			else if (cmd.ins_shift) pos_q <= pos_q - CntBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.ins_shift) order_q[pos_idx] <= order_q[prev_idx];
		if (cmd.rem_shift) order_q[pos_idx] <= order_q[pos_idx + SlotBits'(1)];
		if (cmd.put) order_q[pos_idx] <= item_q.task_slot;
		if (cmd.wr_fields) begin
			pri_q[item_q.task_slot] <= item_q.priority_req;
			state_q[item_q.task_slot] <= item_q.task_state;
			wait_q[item_q.task_slot] <= item_q.resource;
		end
		if (cmd.wr_state) begin
			state_q[item_q.task_slot] <= item_q.task_state;
			wait_q[item_q.task_slot] <= item_q.resource;
		end
		if (cmd.mark_run) state_q[mark_slot] <= ST_RUNNING;
		if (cmd.res_hit) result_q <= '{error: 1'b0, found: 1'b1, result_slot: ent,
			used_idle: 1'b0};
		if (cmd.res_idle) result_q <= '{error: 1'b0, found: 1'b0,
			result_slot: idle_slot, used_idle: 1'b1};
		if (cmd.res_err) result_q <= '{error: 1'b1, found: 1'b0, result_slot: '0,
			used_idle: 1'b0};
		if (cmd.res_none) result_q <= '0;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntBits'(MaxTasks))
		else $error("queue count beyond table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + CntBits'(1))
		else $error("count did not advance on add");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec))
		else $error("count raised and lowered together");
endmodule

// File: design/ptrq_ctrl.sv
module ptrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	output logic                busy,
	output logic                out_valid,
	input  logic                out_ready,
	input  ptrq_pkg::status_t   status,
	output ptrq_pkg::cmd_t      cmd
);
	import ptrq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SHIFT, S_REM_FIND, S_REM_SHIFT, S_SCAN, S_DONE
	} state_t;

	state_t state_q;
	state_t next;
	logic rdy;
	logic dispatch;

	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign rdy = (status.opcode == OP_FIND_READY) || (status.opcode == OP_DISPATCH);
	assign dispatch = (status.opcode == OP_DISPATCH);

	always_comb begin
		cmd = '0;
		next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					next = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.opcode) inside
					OP_ADD: begin
						if (status.queued) begin
							cmd.res_err = 1'b1;
							next = S_DONE;
						end else begin
							cmd.wr_fields = 1'b1;
							cmd.set_q = 1'b1;
							cmd.pos_end = 1'b1;
							cmd.res_none = 1'b1;
							next = S_SHIFT;
						end
					end
					OP_REMOVE: begin
						if (!status.queued) begin
							cmd.res_err = 1'b1;
							next = S_DONE;
						end else begin
							cmd.clr_pos = 1'b1;
							cmd.clr_q = 1'b1;
							cmd.res_none = 1'b1;
							next = S_REM_FIND;
						end
					end
					OP_SET: begin
						if (!status.queued) cmd.res_err = 1'b1;
						else begin
							cmd.wr_state = 1'b1;
							cmd.res_none = 1'b1;
						end
						next = S_DONE;
					end
					OP_FIND_READY, OP_DISPATCH, OP_FIND_WAIT: begin
						cmd.clr_pos = 1'b1;
						next = S_SCAN;
					end
					default: begin
						cmd.res_none = 1'b1;
						next = S_DONE;
					end
				endcase
			end
			S_SHIFT: begin
				// open the gap from the tail down past every larger priority number
				if (!status.at_zero && status.prev_gt) cmd.ins_shift = 1'b1;
				else begin
					cmd.put = 1'b1;
					cmd.cnt_inc = 1'b1;
					next = S_DONE;
				end
			end
			S_REM_FIND: begin
				if (status.is_slot) next = S_REM_SHIFT;
				else cmd.step = 1'b1;
			end
			S_REM_SHIFT: begin
				if (status.at_last) begin
					cmd.cnt_dec = 1'b1;
					next = S_DONE;
				end else cmd.rem_shift = 1'b1;
			end
			S_SCAN: begin
				if (status.at_end) begin
					if (rdy) begin
						cmd.res_idle = 1'b1;
						cmd.mark_run = dispatch;
					end else cmd.res_none = 1'b1;
					next = S_DONE;
				end else if (rdy ? status.is_ready : status.is_wait_match) begin
					cmd.res_hit = 1'b1;
					cmd.mark_run = dispatch;
					next = S_DONE;
				end else cmd.step = 1'b1;
			end
			S_DONE: begin
				if (out_ready) next = S_IDLE;
			end
			default: next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= next;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE)
		else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.res_hit, cmd.res_idle, cmd.res_err, cmd.res_none}))
		else $error("conflicting result commands");
endmodule

// File: design/priority_task_ready_queue.sv
// Priority ordered task ready queue.
// Items arrive on s_axis (tdata, tvalid, tready); one result per item leaves
// on m_axis. The idle slot register is written on cfg (valid, ready, data)
// while the block is idle; cfg_ready is low while an item is in flight.
// An item occupies the block from acceptance through decode and the walk
// until its result is presented and taken by the receiver. An add walks from
// the tail toward the head one entry a cycle while moving larger priority
// numbers one place toward the tail; a remove finds the slot and closes the
// gap; a search visits one entry a cycle. Errors, set state and unknown
// operations have no walk. One item is handled at a time; s_axis_tready is
// low while busy and while a result waits on a stalled receiver, whose data
// holds until taken. Reset clears the queue and the idle slot to 0; table
// contents are undefined until a task is added.
module priority_task_ready_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] opcode, [6:3] task_slot, [14:7] priority_req, [16:15] task_state,
	// [32:17] resource, zero fill
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] error, [1] found, [5:2] result_slot, [6] used_idle, zero fill
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import ptrq_pkg::*;

	logic [SlotBits-1:0] idle_q;
	logic in_fire;
	logic busy;
	item_t item;
	result_t result;
	cmd_t cmd;
	status_t status;

	assign item = item_t'(s_axis_tdata[32:0]);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy;
	assign cfg_ready = !busy;
	assign m_axis_tdata = {1'b0, result};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idle_q <= '0;
		else if (cfg_valid && cfg_ready) idle_q <= cfg_data;
	end

	ptrq_ctrl i_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.busy(busy),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.status(status),
		.cmd(cmd)
	);

	ptrq_datapath i_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.idle_slot(idle_q),
		.cmd(cmd),
		.status(status),
		.result(result)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input open while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("error and found together");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[6]) |-> !m_axis_tdata[1])
		else $error("idle fallback reported as found");
endmodule
